// ----- design/wma_pkg.sv -----
package wma_pkg;

   localparam int unsigned TAPS = 10;
   localparam int unsigned SAMPLE_W = 16;
   // 20 * 65535 fits in 21 bits
   localparam int unsigned SUM_W = 21;
   localparam int unsigned QUO_W = SUM_W - 2;
   localparam int unsigned WEIGHT_W = 3;

   // ceil(2^22 / 5); exact quotient for any 19-bit dividend
   localparam int unsigned RECIP_SHIFT = 22;
   localparam int unsigned RECIP_W = 20;
   localparam logic [RECIP_W-1:0] RECIP_FIVE = RECIP_W'(838861);
   localparam int unsigned PROD_W = QUO_W + RECIP_W;

   localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(20 * 65535);

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SUM_W-1:0] sum_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

   // weights in twentieths, newest tap first
   localparam weight_type TAP_WEIGHT [TAPS] = '{
      3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1
   };

endpackage

// ----- design/wma_if.sv -----
interface wma_req_if
   import wma_pkg::*;
   ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface wma_rsp_if
   import wma_pkg::*;
   ();
   logic       valid;
   logic       ready;
   sample_type smoothed;

   modport source (output valid, output smoothed, input ready);
   modport sink (input valid, input smoothed, output ready);
endinterface

// ----- design/weighted_moving_average_filter.sv -----
// channel     | dir | payload          | handshake
// req_chan    | in  | sample   [15:0]  | valid / ready
// rsp_chan    | out | smoothed [15:0]  | valid / ready
//
// One item per cycle sustained while rsp_chan.ready stays high.
// On accept: the delay line shifts and the weighted sum is registered.
// Once the result stage is free: the sum is divided by 20 (shift by two, multiply by a reciprocal of five)
// into the result register.
// Synchronous reset empties both stages and marks the delay line unprimed.
// A stalled result holds the sum stage; req_chan.ready drops only when both stages are full.
module weighted_moving_average_filter
   import wma_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wma_req_if.sink    req_chan,
   wma_rsp_if.source  rsp_chan
);

   sample_type history_ff [TAPS];
   sample_type history_in [TAPS];
   logic       primed_ff;
   sum_type    sum_ff;
   sum_type    sum_in;
   logic       sum_valid_ff;
   sample_type result_ff;
   logic       result_valid_ff;

   logic                 req_accept;
   logic                 sum_advance;
   logic                 result_free;
   logic [QUO_W-1:0]     quarter;
   logic [PROD_W-1:0]    product;

   assign result_free = !result_valid_ff || rsp_chan.ready;
   assign sum_advance = sum_valid_ff && result_free;
   assign req_chan.ready = !sum_valid_ff || sum_advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   // first item fills every tap, later items shift the line
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         if (!primed_ff || k == 0) begin
            history_in[k] = req_chan.sample;
         end else begin
            history_in[k] = history_ff[k-1];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < TAPS; k++) begin
         sum_in = sum_in + SUM_W'(history_in[k]) * SUM_W'(TAP_WEIGHT[k]);
      end
   end

   // divide by 20: drop two bits, then multiply by the reciprocal of five
   assign quarter = sum_ff[SUM_W-1:2];
   assign product = PROD_W'(quarter) * PROD_W'(RECIP_FIVE);

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            primed_ff <= 1'b1;
            sum_valid_ff <= 1'b1;
         end else if (sum_advance) begin
            sum_valid_ff <= 1'b0;
         end
         if (sum_advance) begin
            result_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            result_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         history_ff <= history_in;
         sum_ff <= sum_in;
      end
      if (sum_advance) begin
         result_ff <= product[RECIP_SHIFT +: SAMPLE_W];
      end
   end

   assign rsp_chan.valid = result_valid_ff;
   assign rsp_chan.smoothed = result_ff;

   hold_sum_on_stall: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && !sum_advance |=> sum_valid_ff && $stable(sum_ff))
      else $error("sum stage lost or changed while stalled");

   ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> sum_valid_ff && result_valid_ff)
      else $error("input stalled with a free stage");

   primed_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> primed_ff && sum_valid_ff)
      else $error("accepted item did not prime the line");

   sum_in_range: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff |-> sum_ff <= SUM_MAX)
      else $error("weighted sum out of range");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import wma_pkg::*;

   localparam int unsigned WEIGHT_TOTAL = 20;
   localparam int unsigned RANDOM_ITEMS = 1850;

   logic clock;
   logic reset;

   wma_req_if req_chan ();
   wma_rsp_if rsp_chan ();

   weighted_moving_average_filter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state: delay line, newest tap first
   sample_type filter_line [TAPS];
   logic line_primed = 1'b0;
   sample_type smoothed_due [$];

   int unsigned failures = 0;
   int unsigned gap_limit = 5;
   int unsigned stall_limit = 5;
   int unsigned hold_off_cycles = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic sample_type next_smoothed(input sample_type value);
      int unsigned weighted;
      // first sample after reset fills every tap and passes through
      if (!line_primed) begin
         foreach (filter_line[k]) filter_line[k] = value;
         line_primed = 1'b1;
         return value;
      end
      for (int k = TAPS - 1; k > 0; k--) filter_line[k] = filter_line[k - 1];
      filter_line[0] = value;
      weighted = 0;
      foreach (filter_line[k])
         weighted += int'(filter_line[k]) * int'(TAP_WEIGHT[k]);
      return sample_type'(weighted / WEIGHT_TOTAL);
   endfunction

   // call at a rising edge; returns at the edge where the item is taken
   task automatic send_sample(input sample_type value);
      int unsigned gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= value;
      do @(posedge clock); while (!req_chan.ready);
      smoothed_due.push_back(next_smoothed(value));
   endtask

   always begin : result_check
      int unsigned stall;
      sample_type expected;
      if (hold_off_cycles > 0) begin
         stall = hold_off_cycles;
         hold_off_cycles = 0;
      end else begin
         stall = $urandom_range(0, stall_limit);
      end
      if (stall > 0) begin
         rsp_chan.ready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_chan.ready <= 1'b1;
      // skip the edges before reset has settled the outputs
      do @(posedge clock);
      while (!(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1 && reset === 1'b0));
      if (smoothed_due.size() == 0) begin
         $error("smoothed: no item expected, actual %0d", rsp_chan.smoothed);
         failures++;
      end else begin
         expected = smoothed_due.pop_front();
         if (rsp_chan.smoothed !== expected) begin
            $error("smoothed: expected %0d, actual %0d", expected, rsp_chan.smoothed);
            failures++;
         end
      end
   end

   task automatic test_first_sample();
      send_sample(16'hFFFF);
   endtask

   task automatic test_step_to_zero();
      repeat (10) send_sample(16'h0000);
   endtask

   task automatic test_full_scale();
      repeat (10) send_sample(16'hFFFF);
   endtask

   task automatic test_alternating_bits();
      send_sample(16'h8000);
      send_sample(16'h0001);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
   endtask

   // receiver holds off while the sender keeps offering items back to back
   task automatic test_back_pressure();
      gap_limit = 0;
      hold_off_cycles = 80;
      repeat (30) send_sample(sample_type'($urandom));
      gap_limit = 5;
   endtask

   task automatic test_random_stream();
      sample_type value;
      value = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // rotate stretches: both idle, no sender gaps, no receiver stalls
         if (n % 200 == 0) begin
            gap_limit = ((n / 200) % 3 == 1) ? 0 : 5;
            stall_limit = ((n / 200) % 3 == 2) ? 0 : 5;
         end
         case ($urandom_range(0, 4))
            0: value = sample_type'($urandom);
            1: value = sample_type'($urandom_range(0, 255));
            2: value = 16'hFF00 | sample_type'($urandom_range(0, 255));
            3: value = value + sample_type'($urandom_range(0, 64)) - 16'd32;
            default: value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         endcase
         send_sample(value);
      end
      gap_limit = 5;
      stall_limit = 5;
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.sample <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_first_sample();
      test_step_to_zero();
      test_full_scale();
      test_alternating_bits();
      test_back_pressure();
      test_random_stream();

      req_chan.valid <= 1'b0;
      while (smoothed_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
